@@ rtl/core/sfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants and helper functions for the sensor frame CRC decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned TempW  = 9;
  localparam int unsigned HumW   = 7;
  localparam int unsigned OutDataW = TempW + HumW;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  localparam logic [ByteW-1:0] TempSpan   = 8'd175;
  localparam logic [ByteW-1:0] HumSpan    = 8'd100;
  localparam logic [WordW:0]   FullScale  = 17'd65535;
  localparam logic [TempW-1:0] TempOffset = 9'd45;

  // reply byte positions
  localparam logic [IdxW-1:0] PosTempMsb = 3'd0;
  localparam logic [IdxW-1:0] PosTempLsb = 3'd1;
  localparam logic [IdxW-1:0] PosTempCrc = 3'd2;
  localparam logic [IdxW-1:0] PosHumMsb  = 3'd3;
  localparam logic [IdxW-1:0] PosHumLsb  = 3'd4;
  localparam logic [IdxW-1:0] PosHumCrc  = 3'd5;

  // CRC-8, MSB first, one byte
  function automatic logic [ByteW-1:0] crc8_byte(logic [ByteW-1:0] crc,
                                                 logic [ByteW-1:0] data);
    logic [ByteW-1:0] v;
    v = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  // floor(span * raw / 65535): quotient from the top bits, one correction step
  function automatic logic [ByteW-1:0] scale_word(logic [WordW-1:0] raw,
                                                  logic [ByteW-1:0] span);
    logic [WordW+ByteW-1:0] prod;
    logic [ByteW-1:0]       q;
    logic [WordW:0]         r;
    prod = {{ByteW{1'b0}}, raw} * {{WordW{1'b0}}, span};
    q    = prod[WordW+ByteW-1:WordW];
    r    = {1'b0, prod[WordW-1:0]} + {{(WordW+1-ByteW){1'b0}}, q};
    if (r >= FullScale) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

@@ rtl/core/sensor_frame_crc_decoder_core.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_core
// Six-byte humidity/temperature reply decoder with CRC-8 pair checks.
// ----------------------------------------------------------------------------
// Takes one reply byte per cycle (1 item/cycle sustained) through an input
// register; CRC update and scaling sit between that register and the result
// register, so a result follows its sixth byte through both of these registers.
// The sixth byte of a reply yields one result item; a failed checksum gives
// zero temperature and humidity with crc_ok low. tuser high on an input byte
// restarts the reply at that byte. Only a full result register that is not
// being drained stalls the input.
module sensor_frame_crc_decoder_core
  import sfcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,  // [7:0] rx_byte
  input  logic                s_axis_tuser,  // [0] frame_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [8:0] temperature_c, [15:9] humidity_pct
  output logic                m_axis_tuser   // [0] crc_ok
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [WordW-1:0] temp_raw_q, temp_raw_d;
  logic [WordW-1:0] hum_raw_q, hum_raw_d;
  logic             temp_ok_q, temp_ok_d;

  logic                    out_valid_q;
  logic signed [TempW-1:0] out_temp_q, out_temp_d;
  logic [HumW-1:0]         out_hum_q, out_hum_d;
  logic                    out_ok_q, out_ok_d;

  logic             proc;
  logic             emit;
  logic [IdxW-1:0]  idx_eff;
  logic [ByteW-1:0] crc_eff;
  logic [ByteW-1:0] crc_next;
  logic             frame_ok;
  logic [ByteW-1:0] temp_scaled;
  logic [ByteW-1:0] hum_scaled;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  always_comb begin
    if (in_start_q || (idx_q > PosHumCrc)) begin
      idx_eff = PosTempMsb;
      crc_eff = CrcInit;
    end else begin
      idx_eff = idx_q;
      crc_eff = crc_q;
    end
  end

  assign crc_next    = crc8_byte(crc_eff, in_byte_q);
  assign frame_ok    = temp_ok_q && (crc_eff == in_byte_q);
  assign temp_scaled = scale_word(temp_raw_q, TempSpan);
  assign hum_scaled  = scale_word(hum_raw_q, HumSpan);

  always_comb begin
    crc_d      = crc_q;
    temp_raw_d = temp_raw_q;
    hum_raw_d  = hum_raw_q;
    temp_ok_d  = temp_ok_q;
    emit       = 1'b0;
    idx_d      = idx_q;
    if (proc) begin
      idx_d = (idx_eff >= PosHumCrc) ? PosTempMsb : idx_eff + 3'd1;
      unique case (idx_eff)
        PosTempMsb: begin
          temp_raw_d = {in_byte_q, {ByteW{1'b0}}};
          crc_d      = crc_next;
        end
        PosTempLsb: begin
          temp_raw_d = {temp_raw_q[WordW-1:ByteW], in_byte_q};
          crc_d      = crc_next;
        end
        PosTempCrc: begin
          temp_ok_d = (crc_eff == in_byte_q);
          crc_d     = CrcInit;
        end
        PosHumMsb: begin
          hum_raw_d = {in_byte_q, {ByteW{1'b0}}};
          crc_d     = crc_next;
        end
        PosHumLsb: begin
          hum_raw_d = {hum_raw_q[WordW-1:ByteW], in_byte_q};
          crc_d     = crc_next;
        end
        default: begin
          emit  = 1'b1;
          crc_d = CrcInit;
        end
      endcase
    end
  end

  always_comb begin
    if (frame_ok) begin
      out_temp_d = $signed({1'b0, temp_scaled} - TempOffset);
      out_hum_d  = hum_scaled[HumW-1:0];
    end else begin
      out_temp_d = '0;
      out_hum_d  = '0;
    end
    out_ok_d = frame_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= PosTempMsb;
      crc_q      <= CrcInit;
      temp_raw_q <= '0;
      hum_raw_q  <= '0;
      temp_ok_q  <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      crc_q      <= crc_d;
      temp_raw_q <= temp_raw_d;
      hum_raw_q  <= hum_raw_d;
      temp_ok_q  <= temp_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_temp_q <= out_temp_d;
      out_hum_q  <= out_hum_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hum_q, out_temp_q};
  assign m_axis_tuser  = out_ok_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= PosHumCrc)
    else $error("byte position out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failed frame carries nonzero data");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:TempW] <= 7'd100)
    else $error("humidity above full scale");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("result lost");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream check of the six-byte humidity/temperature reply decoder.
// A directed table covers the extremes of the scaling and both checksum
// errors, back-to-back replies and a restart in the middle of a reply. Then
// about 2000 random bytes follow. Most form replies with correct CRCs, and
// the rest are corrupted, truncated or plain noise. Each reading is compared
// with the table (directed) or a predictor on the accepted bytes (random).
// Random stalls occur on both sides, with one stretch that has none at all.
// ----------------------------------------------------------------------------
module tb_top;
  import sfcd_pkg::*;

  localparam int unsigned NumRandomBytes = 2000;
  localparam int unsigned IdlePct        = 22;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned NumDirected    = 26;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [HumW-1:0]         hum;
    logic                    ok;
  } reading_t;

  typedef enum logic [1:0] {
    BYTE_AS_IS,
    BYTE_CRC_GOOD,
    BYTE_CRC_BAD
  } fill_e;

  typedef struct packed {
    logic [ByteW-1:0] val;
    logic             start;
    fill_e            fill;
    logic             typed;
    reading_t         exp;
  } vec_t;

  // typed readings: full-scale extremes and checksum errors
  localparam vec_t Directed [NumDirected] = '{
    '{8'h00, 1'b1, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, '0},
    '{8'h00, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1, '{-9'sd45, 7'd0, 1'b1}},
    // next reply without a start flag
    '{8'hFF, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'hFF, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, '0},
    '{8'hFF, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'hFF, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1, '{9'sd130, 7'd100, 1'b1}},
    // bad temperature CRC
    '{8'h66, 1'b1, BYTE_AS_IS,    1'b0, '0},
    '{8'h66, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_BAD,  1'b0, '0},
    '{8'h5A, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'hA5, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1, '{9'sd0, 7'd0, 1'b0}},
    // truncated reply, restart, then bad humidity CRC
    '{8'h11, 1'b1, BYTE_AS_IS,    1'b0, '0},
    '{8'h22, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h80, 1'b1, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, '0},
    '{8'h80, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_AS_IS,    1'b0, '0},
    '{8'h00, 1'b0, BYTE_CRC_BAD,  1'b1, '{9'sd0, 7'd0, 1'b0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;   // [7:0] rx_byte
  logic                s_axis_tuser;   // [0] frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [8:0] temperature_c, [15:9] humidity_pct
  logic                m_axis_tuser;   // [0] crc_ok

  sensor_frame_crc_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted decoder state
  logic [IdxW-1:0]  frm_pos;
  logic [ByteW-1:0] frm_crc;
  logic [WordW-1:0] frm_temp_raw;
  logic [WordW-1:0] frm_hum_raw;
  logic             frm_temp_crc_ok;

  reading_t    pending_readings [$];
  int unsigned idle_pct = IdlePct;
  int unsigned bytes_sent;
  int unsigned readings_seen;
  int unsigned crc_fail_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // bit-serial CRC-8, MSB first
  function automatic logic [ByteW-1:0] crc8_step(logic [ByteW-1:0] acc,
                                                 logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    int               i;
    c = acc;
    for (i = ByteW - 1; i >= 0; i--) begin
      if (c[ByteW-1] ^ b[i]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [ByteW-1:0] pair_crc(logic [WordW-1:0] w);
    return crc8_step(crc8_step(CrcInit, w[WordW-1:ByteW]), w[ByteW-1:0]);
  endfunction

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic start,
                             output logic emit, output reading_t r);
    logic [IdxW-1:0] pos;
    int unsigned     t_scaled;
    int unsigned     h_scaled;
    int              t_deg;
    pos  = frm_pos;
    emit = 1'b0;
    r    = '0;
    if (start || pos > PosHumCrc) begin
      pos     = PosTempMsb;
      frm_crc = CrcInit;
    end
    case (pos)
      PosTempMsb: begin
        frm_temp_raw = {b, 8'h00};
        frm_crc      = crc8_step(frm_crc, b);
      end
      PosTempLsb: begin
        frm_temp_raw[ByteW-1:0] = b;
        frm_crc                 = crc8_step(frm_crc, b);
      end
      PosTempCrc: begin
        frm_temp_crc_ok = (frm_crc == b);
        frm_crc         = CrcInit;
      end
      PosHumMsb: begin
        frm_hum_raw = {b, 8'h00};
        frm_crc     = crc8_step(frm_crc, b);
      end
      PosHumLsb: begin
        frm_hum_raw[ByteW-1:0] = b;
        frm_crc                = crc8_step(frm_crc, b);
      end
      default: begin
        emit = 1'b1;
        if (frm_temp_crc_ok && frm_crc == b) begin
          t_scaled = (175 * int'(frm_temp_raw)) / 65535;
          h_scaled = (100 * int'(frm_hum_raw)) / 65535;
          t_deg    = int'(t_scaled) - 45;
          r.temp   = t_deg[TempW-1:0];
          r.hum    = h_scaled[HumW-1:0];
          r.ok     = 1'b1;
        end
        frm_crc = CrcInit;
      end
    endcase
    frm_pos = (pos >= PosHumCrc) ? PosTempMsb : pos + 3'd1;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic start,
                           input logic use_typed, input reading_t typed_exp);
    logic     emit;
    reading_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    decode_byte(b, start, emit, r);
    if (emit) begin
      pending_readings.push_back(use_typed ? typed_exp : r);
    end
  endtask

  function automatic logic [WordW-1:0] pick_raw_word();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      4:       return 16'h8000;
      5:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // len < 6 gives a truncated reply
  task automatic send_reply(input logic start, input int unsigned len,
                            input logic t_good, input logic h_good);
    logic [WordW-1:0] tw;
    logic [WordW-1:0] hw;
    logic [ByteW-1:0] bytes [6];
    int unsigned      k;
    tw = pick_raw_word();
    hw = pick_raw_word();
    bytes[0] = tw[WordW-1:ByteW];
    bytes[1] = tw[ByteW-1:0];
    bytes[2] = pair_crc(tw) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    bytes[3] = hw[WordW-1:ByteW];
    bytes[4] = hw[ByteW-1:0];
    bytes[5] = pair_crc(hw) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    for (k = 0; k < len; k++) begin
      send_byte(bytes[k], (k == 0) ? start : 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    reading_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      if (!m_axis_tuser) begin
        crc_fail_seen++;
      end
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: temperature_c %0d humidity_pct %0d crc_ok %0b",
               $signed(m_axis_tdata[TempW-1:0]), m_axis_tdata[OutDataW-1:TempW],
               m_axis_tuser);
        mismatches++;
      end else begin
        exp = pending_readings.pop_front();
        if (m_axis_tdata[TempW-1:0] !== exp.temp) begin
          $error("temperature_c: expected %0d, got %0d", exp.temp,
                 $signed(m_axis_tdata[TempW-1:0]));
          mismatches++;
        end
        if (m_axis_tdata[OutDataW-1:TempW] !== exp.hum) begin
          $error("humidity_pct: expected %0d, got %0d", exp.hum,
                 m_axis_tdata[OutDataW-1:TempW]);
          mismatches++;
        end
        if (m_axis_tuser !== exp.ok) begin
          $error("crc_ok: expected %0b, got %0b", exp.ok, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("stalled for %0d cycles with %0d readings outstanding",
               StallLimit, pending_readings.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] prev1;
    logic [ByteW-1:0] prev2;
    int unsigned      i;
    int unsigned      kind;
    int unsigned      n;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    quiet_cycles  <= 0;
    frm_pos         = PosTempMsb;
    frm_crc         = CrcInit;
    frm_temp_raw    = '0;
    frm_hum_raw     = '0;
    frm_temp_crc_ok = 1'b0;
    prev1 = '0;
    prev2 = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDirected; i++) begin
      case (Directed[i].fill)
        BYTE_CRC_GOOD: b = crc8_step(crc8_step(CrcInit, prev2), prev1);
        BYTE_CRC_BAD:  b = crc8_step(crc8_step(CrcInit, prev2), prev1) ^ 8'h01;
        default:       b = Directed[i].val;
      endcase
      send_byte(b, Directed[i].start, Directed[i].typed, Directed[i].exp);
      prev2 = prev1;
      prev1 = b;
    end

    while (bytes_sent < NumDirected + NumRandomBytes) begin
      // no stalls on either side for a stretch in the middle
      idle_pct = (bytes_sent > 900 && bytes_sent < 1300) ? 0 : IdlePct;
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_reply(1'($urandom_range(1)), 6, $urandom_range(9) != 0,
                   $urandom_range(9) != 0);
      end else if (kind < 85) begin
        send_reply(1'b1, $urandom_range(1, 5), 1'b1, 1'b1);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), $urandom_range(99) < 15, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d bytes sent, %0d readings checked, %0d of them with checksum errors",
             bytes_sent, readings_seen, crc_fail_seen);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sfcd_pkg.sv
rtl/core/sensor_frame_crc_decoder_core.sv
dv/tb_top.sv
